// ----- design/ecpa_pkg.sv -----
// ---------------------------------------------------------------------------
// ecpa_pkg: shared definitions for the elliptic curve point unit
// Micro-operation codes, register-file map and the control program.
// ---------------------------------------------------------------------------
package ecpa_pkg;

  localparam int WIDTH_DEF = 64;
  localparam int PC_W      = 7;
  localparam int RA_W      = 5;
  localparam int OP_W      = 5;

  // Micro-operation codes
  localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 5'd1;
  localparam logic [OP_W-1:0] OP_MUL   = 5'd2;
  localparam logic [OP_W-1:0] OP_DIV   = 5'd3;
  localparam logic [OP_W-1:0] OP_REM   = 5'd4;
  localparam logic [OP_W-1:0] OP_MOV   = 5'd5;
  localparam logic [OP_W-1:0] OP_LDIN  = 5'd6;
  localparam logic [OP_W-1:0] OP_JEQ   = 5'd7;
  localparam logic [OP_W-1:0] OP_JNE   = 5'd8;
  localparam logic [OP_W-1:0] OP_JMP   = 5'd9;
  localparam logic [OP_W-1:0] OP_JBZ   = 5'd10;
  localparam logic [OP_W-1:0] OP_JDNZ  = 5'd11;
  localparam logic [OP_W-1:0] OP_BFUNC = 5'd12;
  localparam logic [OP_W-1:0] OP_CALL  = 5'd13;
  localparam logic [OP_W-1:0] OP_RET   = 5'd14;
  localparam logic [OP_W-1:0] OP_FAIL  = 5'd15;
  localparam logic [OP_W-1:0] OP_DONE  = 5'd16;

  // Input field selectors for OP_LDIN
  localparam logic [RA_W-1:0] F_PX   = 5'd0;
  localparam logic [RA_W-1:0] F_PY   = 5'd1;
  localparam logic [RA_W-1:0] F_QX   = 5'd2;
  localparam logic [RA_W-1:0] F_QY   = 5'd3;
  localparam logic [RA_W-1:0] F_A    = 5'd4;
  localparam logic [RA_W-1:0] F_N    = 5'd5;
  localparam logic [RA_W-1:0] F_ZERO = 5'd6;
  localparam logic [RA_W-1:0] F_ONE  = 5'd7;

  // Register-file map
  localparam logic [RA_W-1:0] R_ZERO = 5'd0;
  localparam logic [RA_W-1:0] R_ONE  = 5'd1;
  localparam logic [RA_W-1:0] R_NN   = 5'd2;
  localparam logic [RA_W-1:0] R_A    = 5'd3;
  localparam logic [RA_W-1:0] R_PX   = 5'd4;
  localparam logic [RA_W-1:0] R_PY   = 5'd5;
  localparam logic [RA_W-1:0] R_QX   = 5'd6;
  localparam logic [RA_W-1:0] R_QY   = 5'd7;
  localparam logic [RA_W-1:0] R_AX   = 5'd8;
  localparam logic [RA_W-1:0] R_AY   = 5'd9;
  localparam logic [RA_W-1:0] R_SX   = 5'd10;
  localparam logic [RA_W-1:0] R_SY   = 5'd11;
  localparam logic [RA_W-1:0] R_K    = 5'd12;
  localparam logic [RA_W-1:0] R_D    = 5'd13;
  localparam logic [RA_W-1:0] R_T    = 5'd14;
  localparam logic [RA_W-1:0] R_R0   = 5'd16;
  localparam logic [RA_W-1:0] R_R1   = 5'd17;
  localparam logic [RA_W-1:0] R_S0   = 5'd18;
  localparam logic [RA_W-1:0] R_S1   = 5'd19;
  localparam logic [RA_W-1:0] R_Q    = 5'd20;
  localparam logic [RA_W-1:0] R_RX   = 5'd22;
  localparam logic [RA_W-1:0] R_RY   = 5'd23;
  localparam logic [RA_W-1:0] R_X3   = 5'd24;

  // Program labels
  localparam logic [PC_W-1:0] L_MULT = 7'd21;
  localparam logic [PC_W-1:0] L_LOOP = 7'd25;
  localparam logic [PC_W-1:0] L_DBL  = 7'd33;
  localparam logic [PC_W-1:0] L_PADD = 7'd42;
  localparam logic [PC_W-1:0] L_PNZ  = 7'd47;
  localparam logic [PC_W-1:0] L_QNZ  = 7'd52;
  localparam logic [PC_W-1:0] L_INF  = 7'd61;
  localparam logic [PC_W-1:0] L_GEN  = 7'd64;
  localparam logic [PC_W-1:0] L_INV  = 7'd66;
  localparam logic [PC_W-1:0] L_ILP  = 7'd70;
  localparam logic [PC_W-1:0] L_IEND = 7'd79;
  localparam logic [PC_W-1:0] L_IFL  = 7'd89;
  localparam logic [PC_W-1:0] L_NONE = 7'd0;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [RA_W-1:0] dst;
    logic [RA_W-1:0] sa;
    logic [RA_W-1:0] sb;
    logic [PC_W-1:0] tgt;
  } uword_t;

  function automatic uword_t uw(logic [OP_W-1:0] op, logic [RA_W-1:0] dst,
                                logic [RA_W-1:0] sa, logic [RA_W-1:0] sb,
                                logic [PC_W-1:0] tgt);
    uword_t w;
    w.op  = op;
    w.dst = dst;
    w.sa  = sa;
    w.sb  = sb;
    w.tgt = tgt;
    return w;
  endfunction

  // Control program. Point addition is a subroutine with operands in
  // PX,PY,QX,QY and the sum in RX,RY; the inverse is extended Euclid.
  function automatic uword_t rom(logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      7'd0:  w = uw(OP_LDIN, R_ZERO, F_ZERO, R_ZERO, L_NONE);
      7'd1:  w = uw(OP_LDIN, R_ONE,  F_ONE,  R_ZERO, L_NONE);
      7'd2:  w = uw(OP_LDIN, R_NN,   F_N,    R_ZERO, L_NONE);
      7'd3:  w = uw(OP_LDIN, R_A,    F_A,    R_ZERO, L_NONE);
      7'd4:  w = uw(OP_DIV,  R_T,    R_A,    R_NN,   L_NONE);
      7'd5:  w = uw(OP_REM,  R_A,    R_ZERO, R_ZERO, L_NONE);
      7'd6:  w = uw(OP_LDIN, R_PX,   F_PX,   R_ZERO, L_NONE);
      7'd7:  w = uw(OP_DIV,  R_T,    R_PX,   R_NN,   L_NONE);
      7'd8:  w = uw(OP_REM,  R_PX,   R_ZERO, R_ZERO, L_NONE);
      7'd9:  w = uw(OP_LDIN, R_PY,   F_PY,   R_ZERO, L_NONE);
      7'd10: w = uw(OP_DIV,  R_T,    R_PY,   R_NN,   L_NONE);
      7'd11: w = uw(OP_REM,  R_PY,   R_ZERO, R_ZERO, L_NONE);
      7'd12: w = uw(OP_LDIN, R_QX,   F_QX,   R_ZERO, L_NONE);
      7'd13: w = uw(OP_DIV,  R_T,    R_QX,   R_NN,   L_NONE);
      7'd14: w = uw(OP_REM,  R_QX,   R_ZERO, R_ZERO, L_NONE);
      7'd15: w = uw(OP_LDIN, R_QY,   F_QY,   R_ZERO, L_NONE);
      7'd16: w = uw(OP_DIV,  R_T,    R_QY,   R_NN,   L_NONE);
      7'd17: w = uw(OP_REM,  R_QY,   R_ZERO, R_ZERO, L_NONE);
      7'd18: w = uw(OP_BFUNC, R_ZERO, R_ZERO, R_ZERO, L_MULT);
      7'd19: w = uw(OP_CALL, R_ZERO, R_ZERO, R_ZERO, L_PADD);
      7'd20: w = uw(OP_DONE, R_ZERO, R_RX,   R_RY,   L_NONE);
      // scalar multiplication, lowest bit first
      7'd21: w = uw(OP_MOV,  R_AX,   R_ZERO, R_ZERO, L_NONE);
      7'd22: w = uw(OP_MOV,  R_AY,   R_ZERO, R_ZERO, L_NONE);
      7'd23: w = uw(OP_MOV,  R_SX,   R_PX,   R_ZERO, L_NONE);
      7'd24: w = uw(OP_MOV,  R_SY,   R_PY,   R_ZERO, L_NONE);
      7'd25: w = uw(OP_JBZ,  R_ZERO, R_ZERO, R_ZERO, L_DBL);
      7'd26: w = uw(OP_MOV,  R_PX,   R_AX,   R_ZERO, L_NONE);
      7'd27: w = uw(OP_MOV,  R_PY,   R_AY,   R_ZERO, L_NONE);
      7'd28: w = uw(OP_MOV,  R_QX,   R_SX,   R_ZERO, L_NONE);
      7'd29: w = uw(OP_MOV,  R_QY,   R_SY,   R_ZERO, L_NONE);
      7'd30: w = uw(OP_CALL, R_ZERO, R_ZERO, R_ZERO, L_PADD);
      7'd31: w = uw(OP_MOV,  R_AX,   R_RX,   R_ZERO, L_NONE);
      7'd32: w = uw(OP_MOV,  R_AY,   R_RY,   R_ZERO, L_NONE);
      7'd33: w = uw(OP_MOV,  R_PX,   R_SX,   R_ZERO, L_NONE);
      7'd34: w = uw(OP_MOV,  R_PY,   R_SY,   R_ZERO, L_NONE);
      7'd35: w = uw(OP_MOV,  R_QX,   R_SX,   R_ZERO, L_NONE);
      7'd36: w = uw(OP_MOV,  R_QY,   R_SY,   R_ZERO, L_NONE);
      7'd37: w = uw(OP_CALL, R_ZERO, R_ZERO, R_ZERO, L_PADD);
      7'd38: w = uw(OP_MOV,  R_SX,   R_RX,   R_ZERO, L_NONE);
      7'd39: w = uw(OP_MOV,  R_SY,   R_RY,   R_ZERO, L_NONE);
      7'd40: w = uw(OP_JDNZ, R_ZERO, R_ZERO, R_ZERO, L_LOOP);
      7'd41: w = uw(OP_DONE, R_ZERO, R_AX,   R_AY,   L_NONE);
      // point addition subroutine
      7'd42: w = uw(OP_JNE,  R_ZERO, R_PX,   R_ZERO, L_PNZ);
      7'd43: w = uw(OP_JNE,  R_ZERO, R_PY,   R_ZERO, L_PNZ);
      7'd44: w = uw(OP_MOV,  R_RX,   R_QX,   R_ZERO, L_NONE);
      7'd45: w = uw(OP_MOV,  R_RY,   R_QY,   R_ZERO, L_NONE);
      7'd46: w = uw(OP_RET,  R_ZERO, R_ZERO, R_ZERO, L_NONE);
      7'd47: w = uw(OP_JNE,  R_ZERO, R_QX,   R_ZERO, L_QNZ);
      7'd48: w = uw(OP_JNE,  R_ZERO, R_QY,   R_ZERO, L_QNZ);
      7'd49: w = uw(OP_MOV,  R_RX,   R_PX,   R_ZERO, L_NONE);
      7'd50: w = uw(OP_MOV,  R_RY,   R_PY,   R_ZERO, L_NONE);
      7'd51: w = uw(OP_RET,  R_ZERO, R_ZERO, R_ZERO, L_NONE);
      7'd52: w = uw(OP_JNE,  R_ZERO, R_PX,   R_QX,   L_GEN);
      7'd53: w = uw(OP_JNE,  R_ZERO, R_PY,   R_QY,   L_INF);
      7'd54: w = uw(OP_JEQ,  R_ZERO, R_PY,   R_ZERO, L_INF);
      7'd55: w = uw(OP_MUL,  R_T,    R_PX,   R_PX,   L_NONE);
      7'd56: w = uw(OP_ADD,  R_K,    R_T,    R_T,    L_NONE);
      7'd57: w = uw(OP_ADD,  R_K,    R_K,    R_T,    L_NONE);
      7'd58: w = uw(OP_ADD,  R_K,    R_K,    R_A,    L_NONE);
      7'd59: w = uw(OP_ADD,  R_D,    R_PY,   R_PY,   L_NONE);
      7'd60: w = uw(OP_JMP,  R_ZERO, R_ZERO, R_ZERO, L_INV);
      7'd61: w = uw(OP_MOV,  R_RX,   R_ZERO, R_ZERO, L_NONE);
      7'd62: w = uw(OP_MOV,  R_RY,   R_ZERO, R_ZERO, L_NONE);
      7'd63: w = uw(OP_RET,  R_ZERO, R_ZERO, R_ZERO, L_NONE);
      7'd64: w = uw(OP_SUB,  R_K,    R_PY,   R_QY,   L_NONE);
      7'd65: w = uw(OP_SUB,  R_D,    R_PX,   R_QX,   L_NONE);
      7'd66: w = uw(OP_MOV,  R_R0,   R_NN,   R_ZERO, L_NONE);
      7'd67: w = uw(OP_MOV,  R_R1,   R_D,    R_ZERO, L_NONE);
      7'd68: w = uw(OP_MOV,  R_S0,   R_ZERO, R_ZERO, L_NONE);
      7'd69: w = uw(OP_MOV,  R_S1,   R_ONE,  R_ZERO, L_NONE);
      7'd70: w = uw(OP_JEQ,  R_ZERO, R_R1,   R_ZERO, L_IEND);
      7'd71: w = uw(OP_DIV,  R_Q,    R_R0,   R_R1,   L_NONE);
      7'd72: w = uw(OP_MOV,  R_R0,   R_R1,   R_ZERO, L_NONE);
      7'd73: w = uw(OP_REM,  R_R1,   R_ZERO, R_ZERO, L_NONE);
      7'd74: w = uw(OP_MUL,  R_T,    R_S1,   R_Q,    L_NONE);
      7'd75: w = uw(OP_SUB,  R_T,    R_S0,   R_T,    L_NONE);
      7'd76: w = uw(OP_MOV,  R_S0,   R_S1,   R_ZERO, L_NONE);
      7'd77: w = uw(OP_MOV,  R_S1,   R_T,    R_ZERO, L_NONE);
      7'd78: w = uw(OP_JMP,  R_ZERO, R_ZERO, R_ZERO, L_ILP);
      7'd79: w = uw(OP_JNE,  R_ZERO, R_R0,   R_ONE,  L_IFL);
      7'd80: w = uw(OP_MUL,  R_K,    R_K,    R_S0,   L_NONE);
      7'd81: w = uw(OP_MUL,  R_T,    R_K,    R_K,    L_NONE);
      7'd82: w = uw(OP_SUB,  R_T,    R_T,    R_PX,   L_NONE);
      7'd83: w = uw(OP_SUB,  R_X3,   R_T,    R_QX,   L_NONE);
      7'd84: w = uw(OP_SUB,  R_T,    R_PX,   R_X3,   L_NONE);
      7'd85: w = uw(OP_MUL,  R_T,    R_K,    R_T,    L_NONE);
      7'd86: w = uw(OP_SUB,  R_RY,   R_T,    R_PY,   L_NONE);
      7'd87: w = uw(OP_MOV,  R_RX,   R_X3,   R_ZERO, L_NONE);
      7'd88: w = uw(OP_RET,  R_ZERO, R_ZERO, R_ZERO, L_NONE);
      7'd89: w = uw(OP_FAIL, R_ZERO, R_D,    R_ZERO, L_NONE);
      default: w = uw(OP_FAIL, R_ZERO, R_D,  R_ZERO, L_NONE);
    endcase
    return w;
  endfunction

endpackage

// ----- design/ec_point_add_scalar_mul_mod_n.sv -----
// ---------------------------------------------------------------------------
// ec_point_add_scalar_mul_mod_n: affine Weierstrass point arithmetic mod N
// Point addition or lowest-bit-first scalar multiplication for ECM, run by
// a microcoded sequencer over a 32-entry register file and a serial unit.
// ---------------------------------------------------------------------------
// One item is in flight at a time; a finished result waits in the output
// register while the next beat is taken. The time an item takes depends
// on the data: modular multiplies and divisions run in the shared
// bit-serial unit, and each non-trivial point addition runs an extended
// Euclid inverse, with a division and a multiply per quotient step, plus
// three multiplies (four for a doubling); a scalar multiplication performs
// one doubling per scalar bit up to the highest set bit and one addition
// per set bit.
module ec_point_add_scalar_mul_mod_n #(
  parameter int WIDTH = ecpa_pkg::WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // tdata: p_x, p_y, q_x, q_y, scalar (lowest bits first)
  input  logic [((5*WIDTH+7)/8)*8-1:0] in_tdata,
  // tuser: func
  input  logic                        in_tuser,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // tdata: r_x, r_y, factor_candidate (lowest bits first)
  output logic [((3*WIDTH+7)/8)*8-1:0] out_tdata,
  // tuser: status
  output logic                        out_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [WIDTH-1:0]            cfg_wdata
);

  localparam int OUT_W = ((3*WIDTH+7)/8)*8;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int RF_N  = 2**ecpa_pkg::RA_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_WT   = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  localparam logic CFG_CURVE_A = 1'b0;
  localparam logic CFG_MODULUS = 1'b1;

  logic [2:0]                  state_r, state_nxt;
  logic [ecpa_pkg::PC_W-1:0]   pc_r, pc_nxt, ret_r;
  ecpa_pkg::uword_t            uw;

  logic [WIDTH-1:0] curve_a_r, modulus_r, n_eff;
  logic [WIDTH-1:0] n_r, px_in_r, py_in_r, qx_in_r, qy_in_r, scal_r;
  logic             func_r;

  logic [WIDTH-1:0] rf [RF_N];
  logic [WIDTH-1:0] rd_a_r, rd_b_r;
  logic             rf_we;
  logic [WIDTH-1:0] rf_wd;
  logic [WIDTH-1:0] fld;

  // serial unit
  logic             u_div_r, u_ph_r;
  logic [CNT_W-1:0] u_cnt_r;
  logic [WIDTH:0]   u_acc_r;
  logic [WIDTH-1:0] u_sh_r, u_opa_r;
  logic [WIDTH:0]   dv_t, dv_d;
  logic             dv_ge;
  logic             u_last;

  logic [WIDTH-1:0] out_rx_r, out_ry_r, out_fc_r;
  logic             out_st_r, out_valid_r;
  logic             out_free;

  function automatic logic [WIDTH-1:0] add_m(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b,
                                             logic [WIDTH-1:0] n);
    logic [WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] sub_m(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b,
                                             logic [WIDTH-1:0] n);
    logic [WIDTH-1:0] d;
    d = a - b;
    if (a < b) begin
      d = d + n;
    end
    return d;
  endfunction

  assign uw        = ecpa_pkg::rom(pc_r);
  assign n_eff     = (modulus_r < WIDTH'(3)) ? WIDTH'(3) : modulus_r;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_a_r <= '0;
      modulus_r <= WIDTH'(3);
    end else if (cfg_we) begin
      if (cfg_index == CFG_CURVE_A) begin
        curve_a_r <= cfg_wdata;
      end
      if (cfg_index == CFG_MODULUS) begin
        modulus_r <= cfg_wdata;
      end
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      px_in_r <= in_tdata[WIDTH-1:0];
      py_in_r <= in_tdata[2*WIDTH-1:WIDTH];
      qx_in_r <= in_tdata[3*WIDTH-1:2*WIDTH];
      qy_in_r <= in_tdata[4*WIDTH-1:3*WIDTH];
      func_r  <= in_tuser;
      n_r     <= n_eff;
    end
  end

  // Input field selection for loads
  always_comb begin
    case (uw.sa)
      ecpa_pkg::F_PX:   fld = px_in_r;
      ecpa_pkg::F_PY:   fld = py_in_r;
      ecpa_pkg::F_QX:   fld = qx_in_r;
      ecpa_pkg::F_QY:   fld = qy_in_r;
      ecpa_pkg::F_A:    fld = curve_a_r;
      ecpa_pkg::F_N:    fld = n_r;
      ecpa_pkg::F_ONE:  fld = WIDTH'(1);
      default:          fld = '0;
    endcase
  end

  // Register file write data
  always_comb begin
    rf_we = 1'b0;
    rf_wd = rd_a_r;
    if (state_r == S_EX) begin
      unique case (uw.op)
        ecpa_pkg::OP_ADD:  begin rf_we = 1'b1; rf_wd = add_m(rd_a_r, rd_b_r, n_r); end
        ecpa_pkg::OP_SUB:  begin rf_we = 1'b1; rf_wd = sub_m(rd_a_r, rd_b_r, n_r); end
        ecpa_pkg::OP_MOV:  begin rf_we = 1'b1; rf_wd = rd_a_r; end
        ecpa_pkg::OP_LDIN: begin rf_we = 1'b1; rf_wd = fld; end
        ecpa_pkg::OP_REM:  begin rf_we = 1'b1; rf_wd = u_acc_r[WIDTH-1:0]; end
        default:           rf_we = 1'b0;
      endcase
    end else if (state_r == S_WB) begin
      rf_we = 1'b1;
      rf_wd = u_div_r ? u_sh_r : u_acc_r[WIDTH-1:0];
    end
  end

  // Register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[uw.dst] <= rf_wd;
    end
    rd_a_r <= rf[uw.sa];
    rd_b_r <= rf[uw.sb];
  end

  // Serial unit: shift-add modular multiply or restoring division. The
  // remainder of a division stays in the accumulator until the next
  // multiply or divide starts, so later steps can still pick it up.
  assign dv_t   = {u_acc_r[WIDTH-1:0], u_sh_r[WIDTH-1]};
  assign dv_d   = {1'b0, u_opa_r};
  assign dv_ge  = (dv_t >= dv_d);
  assign u_last = (u_cnt_r == '0) && (u_div_r || u_ph_r);

  always_ff @(posedge clk) begin
    if (state_r == S_EX &&
        (uw.op == ecpa_pkg::OP_MUL || uw.op == ecpa_pkg::OP_DIV)) begin
      u_div_r <= (uw.op == ecpa_pkg::OP_DIV);
      u_ph_r  <= 1'b0;
      u_cnt_r <= CNT_W'(WIDTH-1);
      u_acc_r <= '0;
      if (uw.op == ecpa_pkg::OP_DIV) begin
        u_sh_r  <= rd_a_r;
        u_opa_r <= rd_b_r;
      end else begin
        u_sh_r  <= rd_b_r;
        u_opa_r <= rd_a_r;
      end
    end else if (state_r == S_WT) begin
      if (u_div_r) begin
        u_acc_r <= dv_ge ? (dv_t - dv_d) : dv_t;
        u_sh_r  <= {u_sh_r[WIDTH-2:0], dv_ge};
        u_cnt_r <= u_cnt_r - CNT_W'(1);
      end else if (!u_ph_r) begin
        u_acc_r <= {1'b0, add_m(u_acc_r[WIDTH-1:0], u_acc_r[WIDTH-1:0], n_r)};
        u_ph_r  <= 1'b1;
      end else begin
        if (u_sh_r[WIDTH-1]) begin
          u_acc_r <= {1'b0, add_m(u_acc_r[WIDTH-1:0], u_opa_r, n_r)};
        end
        u_sh_r  <= {u_sh_r[WIDTH-2:0], 1'b0};
        u_ph_r  <= 1'b0;
        u_cnt_r <= u_cnt_r - CNT_W'(1);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_RD;
          pc_nxt    = '0;
        end
      end
      S_RD: state_nxt = S_EX;
      S_EX: begin
        state_nxt = S_RD;
        pc_nxt    = pc_r + ecpa_pkg::PC_W'(1);
        unique case (uw.op)
          ecpa_pkg::OP_MUL, ecpa_pkg::OP_DIV: begin
            state_nxt = S_WT;
            pc_nxt    = pc_r;
          end
          ecpa_pkg::OP_JEQ:   if (rd_a_r == rd_b_r) pc_nxt = uw.tgt;
          ecpa_pkg::OP_JNE:   if (rd_a_r != rd_b_r) pc_nxt = uw.tgt;
          ecpa_pkg::OP_JMP:   pc_nxt = uw.tgt;
          ecpa_pkg::OP_JBZ:   if (!scal_r[0]) pc_nxt = uw.tgt;
          ecpa_pkg::OP_JDNZ:  if (scal_r[WIDTH-1:1] != '0) pc_nxt = uw.tgt;
          ecpa_pkg::OP_BFUNC: if (func_r) pc_nxt = uw.tgt;
          ecpa_pkg::OP_CALL:  pc_nxt = uw.tgt;
          ecpa_pkg::OP_RET:   pc_nxt = ret_r;
          ecpa_pkg::OP_FAIL, ecpa_pkg::OP_DONE: begin
            if (out_free) begin
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_EX;
              pc_nxt    = pc_r;
            end
          end
          default: ;
        endcase
      end
      S_WT: if (u_last) state_nxt = S_WB;
      S_WB: begin
        state_nxt = S_RD;
        pc_nxt    = pc_r + ecpa_pkg::PC_W'(1);
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  // Return address and scalar shifter
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      scal_r <= in_tdata[5*WIDTH-1:4*WIDTH];
    end else if (state_r == S_EX && uw.op == ecpa_pkg::OP_JDNZ) begin
      scal_r <= {1'b0, scal_r[WIDTH-1:1]};
    end
    if (state_r == S_EX && uw.op == ecpa_pkg::OP_CALL) begin
      ret_r <= pc_r + ecpa_pkg::PC_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EX && out_free &&
                 (uw.op == ecpa_pkg::OP_DONE || uw.op == ecpa_pkg::OP_FAIL)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EX && out_free) begin
      if (uw.op == ecpa_pkg::OP_DONE) begin
        out_rx_r <= rd_a_r;
        out_ry_r <= rd_b_r;
        out_fc_r <= '0;
        out_st_r <= 1'b0;
      end else if (uw.op == ecpa_pkg::OP_FAIL) begin
        out_rx_r <= '0;
        out_ry_r <= '0;
        out_fc_r <= rd_a_r;
        out_st_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = OUT_W'({out_fc_r, out_ry_r, out_rx_r});

endmodule

// ----- design/ecpa_chk.sv -----
// ---------------------------------------------------------------------------
// ecpa_chk: port-level checks for the elliptic curve point unit
// Watches the handshakes and result encoding; bound to the top level.
// ---------------------------------------------------------------------------
module ecpa_chk #(
  parameter int WIDTH = ecpa_pkg::WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [((3*WIDTH+7)/8)*8-1:0] out_tdata,
  input logic                         out_tuser,
  input logic                         out_tvalid,
  input logic                         out_tready
);

  // A pending result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A failed operation reports the point as zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2*WIDTH-1:0] == '0)
    else $error("failure beat carries a nonzero point");

  // A successful operation reports no factor candidate.
  a_ok_nofac: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[3*WIDTH-1:2*WIDTH] == '0)
    else $error("success beat carries a factor candidate");

  // After taking a beat the block is busy with it.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is in work");

endmodule

bind ec_point_add_scalar_mul_mod_n ecpa_chk #(.WIDTH(WIDTH)) u_ecpa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
